@@ hdl/telnet_stream_filter_unit_defines.svh @@
// Assertion macros shared by the filter's RTL.
`ifndef TELNET_STREAM_FILTER_UNIT_DEFINES_SVH
`define TELNET_STREAM_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsf assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsf assertion failed");

`endif

@@ hdl/tsf_pkg.sv @@
package tsf_pkg;

  localparam int COUNT_WIDTH_DEF = 17;
  localparam int CFG_TIMEOUT_W   = 17;
  localparam int CFG_DATA_W      = 17;
  localparam int CFG_IDX_W       = 1;
  localparam logic [CFG_TIMEOUT_W-1:0] TIMEOUT_RST = CFG_TIMEOUT_W'(100000);

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] OPT_BINARY = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TELNET_EN = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_NET  = 2'd0,
    REQ_TICK = 2'd1,
    REQ_HOST = 2'd2,
    REQ_LOST = 2'd3
  } req_t;

  localparam logic DEST_HOST = 1'b0;
  localparam logic DEST_NET  = 1'b1;

  typedef enum logic [6:0] {
    S_DATA     = 7'b0000001,
    S_CAND     = 7'b0000010,
    S_CAND_OPT = 7'b0000100,
    S_CMD      = 7'b0001000,
    S_OPT      = 7'b0010000,
    S_SUB      = 7'b0100000,
    S_SUB_IAC  = 7'b1000000
  } parse_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Up to three result bytes caused by one input beat; all share one destination.
  typedef struct packed {
    logic       dest;
    logic [1:0] num;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } bundle_t;

  typedef struct packed {
    logic holding;
    logic confirmed;
  } status_t;

  function automatic logic is_verb(input logic [7:0] b);
    return (b == B_WILL) || (b == B_WONT) || (b == B_DO) || (b == B_DONT);
  endfunction

  function automatic bundle_t one_byte(input logic dest, input logic [7:0] b);
    bundle_t r;
    r      = '0;
    r.dest = dest;
    r.num  = 2'd1;
    r.b0   = b;
    return r;
  endfunction

  function automatic bundle_t two_bytes(input logic dest, input logic [7:0] a,
                                        input logic [7:0] b);
    bundle_t r;
    r      = '0;
    r.dest = dest;
    r.num  = 2'd2;
    r.b0   = a;
    r.b1   = b;
    return r;
  endfunction

  // Reply to WILL/DO: binary is accepted, anything else refused. WONT/DONT get none.
  function automatic bundle_t answer_option(input logic [7:0] verb, input logic [7:0] opt);
    bundle_t r;
    r      = '0;
    r.dest = DEST_NET;
    r.b0   = B_IAC;
    r.b2   = opt;
    if (verb == B_WILL) begin
      r.num = 2'd3;
      r.b1  = (opt == OPT_BINARY) ? B_DO : B_DONT;
    end else if (verb == B_DO) begin
      r.num = 2'd3;
      r.b1  = (opt == OPT_BINARY) ? B_WILL : B_WONT;
    end
    return r;
  endfunction

endpackage

@@ hdl/tsf_stream_if.sv @@
interface tsf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/tsf_parser.sv @@
module tsf_parser #(
  parameter int COUNT_WIDTH = tsf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_telnet_en,
  input  logic [tsf_pkg::CFG_TIMEOUT_W-1:0]   cfg_timeout,
  input  logic                                step,
  input  tsf_pkg::in_item_t                   item,
  output tsf_pkg::bundle_t                    bundle,
  output tsf_pkg::status_t                    status
);
  import tsf_pkg::*;

  parse_state_t           st_r, st_nxt;
  logic [7:0]             verb_r, verb_nxt;
  logic                   conf_r, conf_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_load;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [7:0]             b;

  // A timeout wider than the counter saturates at the counter's largest value.
  if (COUNT_WIDTH >= CFG_TIMEOUT_W) begin : g_wide
    assign cnt_load = COUNT_WIDTH'(cfg_timeout);
  end else begin : g_narrow
    assign cnt_load = (cfg_timeout > CFG_TIMEOUT_W'({COUNT_WIDTH{1'b1}})) ?
                      {COUNT_WIDTH{1'b1}} : cfg_timeout[COUNT_WIDTH-1:0];
  end

  assign b       = item.data_byte;
  assign cnt_dec = (cnt_r != '0) ? cnt_r - COUNT_WIDTH'(1) : '0;

  always_comb begin
    st_nxt   = st_r;
    verb_nxt = verb_r;
    conf_nxt = conf_r;
    cnt_nxt  = cnt_r;
    bundle   = '0;
    unique case (req_t'(item.req_type))
      REQ_NET: begin
        if (!cfg_telnet_en) begin
          bundle = one_byte(DEST_HOST, b);
        end else begin
          unique case (st_r)
            S_CAND: begin
              cnt_nxt = '0;
              if (b == B_IAC) begin
                bundle = two_bytes(DEST_HOST, B_IAC, B_IAC);
                st_nxt = S_DATA;
              end else if (is_verb(b)) begin
                verb_nxt = b;
                st_nxt   = S_CAND_OPT;
              end else begin
                bundle = two_bytes(DEST_HOST, B_IAC, b);
                st_nxt = S_DATA;
              end
            end
            S_CAND_OPT: begin
              conf_nxt = 1'b1;
              bundle   = answer_option(verb_r, b);
              st_nxt   = S_DATA;
            end
            S_CMD: begin
              if (b == B_IAC) begin
                bundle = one_byte(DEST_HOST, b);
                st_nxt = S_DATA;
              end else if (is_verb(b)) begin
                verb_nxt = b;
                st_nxt   = S_OPT;
              end else if (b == B_SB) begin
                st_nxt = S_SUB;
              end else begin
                st_nxt = S_DATA;
              end
            end
            S_OPT: begin
              bundle = answer_option(verb_r, b);
              st_nxt = S_DATA;
            end
            S_SUB: begin
              if (b == B_IAC) st_nxt = S_SUB_IAC;
            end
            S_SUB_IAC: begin
              st_nxt = (b == B_SE) ? S_DATA : S_SUB;
            end
            default: begin
              // Data state; unused encodings behave the same way.
              if (b == B_IAC) begin
                if (conf_r) begin
                  st_nxt = S_CMD;
                end else begin
                  st_nxt  = S_CAND;
                  cnt_nxt = cnt_load;
                end
              end else begin
                st_nxt = S_DATA;
                bundle = one_byte(DEST_HOST, b);
              end
            end
          endcase
        end
      end
      REQ_TICK: begin
        if (st_r == S_CAND) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            bundle = one_byte(DEST_HOST, B_IAC);
            st_nxt = S_DATA;
          end
        end
      end
      REQ_HOST: begin
        if (conf_r && (b == B_IAC)) bundle = two_bytes(DEST_NET, b, b);
        else bundle = one_byte(DEST_NET, b);
      end
      default: begin
        // Connection lost: flush a held IAC and return to the reset state.
        if (st_r == S_CAND) bundle = one_byte(DEST_HOST, B_IAC);
        st_nxt   = S_DATA;
        verb_nxt = '0;
        conf_nxt = 1'b0;
        cnt_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_DATA;
      verb_r <= '0;
      conf_r <= 1'b0;
      cnt_r  <= '0;
    end else if (step) begin
      st_r   <= st_nxt;
      verb_r <= verb_nxt;
      conf_r <= conf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign status.holding   = (st_r == S_CAND);
  assign status.confirmed = conf_r;

endmodule

@@ hdl/tsf_out_queue.sv @@
module tsf_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  tsf_pkg::bundle_t bundle,
  output logic             can_load,
  tsf_stream_if.source     out_if
);
  import tsf_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  logic       dest_r;
  logic [7:0] b0_r, b1_r, b2_r;
  logic       beat;

  assign beat     = out_if.valid && out_if.ready;
  // Room for a new bundle once the final beat of the current one leaves.
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_if.ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) cnt_nxt = bundle.num;
    else if (beat) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dest_r <= bundle.dest;
      b0_r   <= bundle.b0;
      b1_r   <= bundle.b1;
      b2_r   <= bundle.b2;
    end else if (beat) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

  assign out_if.valid         = (cnt_r != 2'd0);
  assign out_if.data.dest     = dest_r;
  assign out_if.data.out_byte = b0_r;
  assign out_if.data.last     = (cnt_r == 2'd1);

endmodule

@@ hdl/telnet_stream_filter_unit.sv @@
// Path: an accepted input beat waits in the input register, and its results then go to
// the output queue register. Throughput: one input beat per cycle while out_if.ready is
// high and each gives at most one result; more results hold the input until the last leaves.
// Reset (rst_n low, synchronous): parser back to the data state, nothing held,
// telnet_enabled to 1, candidate_timeout to 100000.
`include "telnet_stream_filter_unit_defines.svh"

module telnet_stream_filter_unit #(
  parameter int COUNT_WIDTH = tsf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  tsf_stream_if.sink                      in_if,
  tsf_stream_if.source                    out_if
);
  import tsf_pkg::*;

  logic                     telnet_en_r;
  logic [CFG_TIMEOUT_W-1:0] timeout_r;
  logic                     in_v_r, in_v_nxt;
  in_item_t                 in_item_r;
  logic                     can_load;
  logic                     step;
  logic                     accept;
  bundle_t                  bundle;
  status_t                  status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      telnet_en_r <= 1'b1;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TELNET_EN: telnet_en_r <= cfg_wdata[0];
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata[CFG_TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign step        = in_v_r && can_load;
  assign in_if.ready = !in_v_r || step;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) in_v_nxt = 1'b1;
    else if (step) in_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_item_r <= in_if.data;
  end

  tsf_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_telnet_en (telnet_en_r),
    .cfg_timeout   (timeout_r),
    .step          (step),
    .item          (in_item_r),
    .bundle        (bundle),
    .status        (status)
  );

  tsf_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .bundle   (bundle),
    .can_load (can_load),
    .out_if   (out_if)
  );

  // A beat that is not the last of its input must be followed by another.
  `TSF_ASSERT_NEXT(a_burst_continues, out_if.valid && out_if.ready && !out_if.data.last, out_if.valid)
  // Input backpressure only comes from a held input beat.
  `TSF_ASSERT_NOW(a_ready_means_room, !in_if.ready, in_v_r)
  // Connection loss always drops the Telnet confirmation and any held IAC.
  `TSF_ASSERT_NEXT(a_lost_clears, step && (in_item_r.req_type == REQ_LOST), !status.confirmed && !status.holding)

endmodule

@@ test/tsf_filter_checker.sv @@
`timescale 1ns / 100ps

module tsf_filter_checker
  import tsf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  in_item_t                in_beat,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  out_item_t               out_beat,
  output int unsigned             error_count,
  output int unsigned             queued_count,
  output int unsigned             checked_count
);

  localparam int CW = COUNT_WIDTH_DEF;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  // Shadow of the configuration registers and of the parser state.
  logic                     parse_en;
  logic [CFG_TIMEOUT_W-1:0] hold_ticks_cfg;
  parse_state_t             pstate;
  logic [7:0]               last_verb;
  logic                     peer_telnet;
  logic [CW-1:0]            hold_left;

  out_item_t step_bytes [3];
  int        step_n;
  out_item_t expected_out [$];
  out_item_t want;

  function automatic logic negotiation_verb(input logic [7:0] b);
    return b == B_WILL || b == B_WONT || b == B_DO || b == B_DONT;
  endfunction

  function automatic void note_byte(input logic dest, input logic [7:0] b);
    step_bytes[step_n].dest     = dest;
    step_bytes[step_n].out_byte = b;
    step_bytes[step_n].last     = 1'b0;
    step_n++;
  endfunction

  // WILL gets DO/DONT, DO gets WILL/WONT; only the binary option is accepted.
  function automatic void reply_to_option(input logic [7:0] opt);
    if (last_verb == B_WILL) begin
      note_byte(DEST_NET, B_IAC);
      note_byte(DEST_NET, (opt == OPT_BINARY) ? B_DO : B_DONT);
      note_byte(DEST_NET, opt);
    end else if (last_verb == B_DO) begin
      note_byte(DEST_NET, B_IAC);
      note_byte(DEST_NET, (opt == OPT_BINARY) ? B_WILL : B_WONT);
      note_byte(DEST_NET, opt);
    end
  endfunction

  function automatic void parse_net_byte(input logic [7:0] b);
    if (!parse_en) begin
      note_byte(DEST_HOST, b);
      return;
    end
    case (pstate)
      S_CAND: begin
        hold_left = '0;
        if (b == B_IAC) begin
          note_byte(DEST_HOST, B_IAC);
          note_byte(DEST_HOST, B_IAC);
          pstate = S_DATA;
        end else if (negotiation_verb(b)) begin
          last_verb = b;
          pstate    = S_CAND_OPT;
        end else begin
          note_byte(DEST_HOST, B_IAC);
          note_byte(DEST_HOST, b);
          pstate = S_DATA;
        end
      end
      S_CAND_OPT: begin
        peer_telnet = 1'b1;
        reply_to_option(b);
        pstate = S_DATA;
      end
      S_CMD: begin
        if (b == B_IAC) begin
          note_byte(DEST_HOST, b);
          pstate = S_DATA;
        end else if (negotiation_verb(b)) begin
          last_verb = b;
          pstate    = S_OPT;
        end else if (b == B_SB) begin
          pstate = S_SUB;
        end else begin
          pstate = S_DATA;
        end
      end
      S_OPT: begin
        reply_to_option(b);
        pstate = S_DATA;
      end
      S_SUB: begin
        if (b == B_IAC) pstate = S_SUB_IAC;
      end
      S_SUB_IAC: begin
        pstate = (b == B_SE) ? S_DATA : S_SUB;
      end
      default: begin
        if (b == B_IAC) begin
          if (peer_telnet) begin
            pstate = S_CMD;
          end else begin
            pstate    = S_CAND;
            hold_left = (32'(hold_ticks_cfg) > 32'(COUNT_MAX)) ? COUNT_MAX : CW'(hold_ticks_cfg);
          end
        end else begin
          pstate = S_DATA;
          note_byte(DEST_HOST, b);
        end
      end
    endcase
  endfunction

  function automatic void predict_filter_out(input in_item_t it);
    step_n = 0;
    case (req_t'(it.req_type))
      REQ_NET: parse_net_byte(it.data_byte);
      REQ_TICK: begin
        if (pstate == S_CAND) begin
          if (hold_left != '0) hold_left = hold_left - CW'(1);
          if (hold_left == '0) begin
            note_byte(DEST_HOST, B_IAC);
            pstate = S_DATA;
          end
        end
      end
      REQ_HOST: begin
        note_byte(DEST_NET, it.data_byte);
        if (peer_telnet && it.data_byte == B_IAC) note_byte(DEST_NET, it.data_byte);
      end
      default: begin
        // Connection lost: a held IAC still reaches the host.
        if (pstate == S_CAND) note_byte(DEST_HOST, B_IAC);
        pstate      = S_DATA;
        last_verb   = '0;
        peer_telnet = 1'b0;
        hold_left   = '0;
      end
    endcase
    for (int i = 0; i < step_n; i++) begin
      step_bytes[i].last = (i == step_n - 1);
      expected_out.push_back(step_bytes[i]);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_en       = 1'b1;
      hold_ticks_cfg = TIMEOUT_RST;
      pstate         = S_DATA;
      last_verb      = '0;
      peer_telnet    = 1'b0;
      hold_left      = '0;
      error_count    = 0;
      checked_count  = 0;
      expected_out.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TELNET_EN: parse_en = cfg_wdata[0];
          CFG_TIMEOUT:   hold_ticks_cfg = cfg_wdata[CFG_TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_filter_out(in_beat);
      if (out_valid && out_ready) begin
        checked_count++;
        if (expected_out.size() == 0) begin
          error_count++;
          $display("%0t: out beat with nothing expected: dest=%0d byte=0x%02h last=%0d",
                   $time, out_beat.dest, out_beat.out_byte, out_beat.last);
        end else begin
          want = expected_out.pop_front();
          if (want.dest !== out_beat.dest || want.out_byte !== out_beat.out_byte ||
              want.last !== out_beat.last) begin
            error_count++;
            $display("%0t: out beat mismatch: expected dest=%0d byte=0x%02h last=%0d,",
                     $time, want.dest, want.out_byte, want.last);
            $display("%0t:   got dest=%0d byte=0x%02h last=%0d",
                     $time, out_beat.dest, out_beat.out_byte, out_beat.last);
          end
        end
      end
    end
    queued_count = expected_out.size();
  end

endmodule

@@ test/tb_telnet_stream_filter_unit.sv @@
`timescale 1ns / 100ps

module tb_telnet_stream_filter_unit;
  import tsf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int          PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 42;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int unsigned error_count;
  int unsigned queued_count;
  int unsigned checked_count;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned random_items;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  in_item_t stim_q [$];

  tsf_stream_if #(.T(in_item_t))  in_if ();
  tsf_stream_if #(.T(out_item_t)) out_if ();

  telnet_stream_filter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  tsf_filter_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_beat       (in_if.data),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_beat      (out_if.data),
    .error_count   (error_count),
    .queued_count  (queued_count),
    .checked_count (checked_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_telnet_stream_filter_unit: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic queue_beat(input req_t req, input logic [7:0] b);
    in_item_t it;
    it.req_type  = req;
    it.data_byte = b;
    stim_q.push_back(it);
    random_items++;
  endtask

  // One well-formed stretch of traffic with random content, or a little noise.
  task automatic add_sequence(input int unsigned hold_ticks);
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      queue_beat(REQ_NET, 8'($urandom_range(254)));
    end else if (pick < 50) begin
      queue_beat(REQ_NET, B_IAC);
      queue_beat(REQ_NET, 8'(B_WILL + $urandom_range(3)));
      queue_beat(REQ_NET, $urandom_range(1) ? OPT_BINARY : 8'($urandom));
    end else if (pick < 57) begin
      queue_beat(REQ_NET, B_IAC);
      queue_beat(REQ_NET, B_IAC);
    end else if (pick < 63) begin
      queue_beat(REQ_NET, B_IAC);
      queue_beat(REQ_NET, 8'($urandom));
    end else if (pick < 71) begin
      queue_beat(REQ_NET, B_IAC);
      queue_beat(REQ_NET, B_SB);
      n = $urandom_range(4);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(254));
        if (b == B_SE) b = 8'h18;
        // An IAC inside the subnegotiation that is not followed by SE.
        if ($urandom_range(3) == 0) queue_beat(REQ_NET, B_IAC);
        queue_beat(REQ_NET, b);
      end
      queue_beat(REQ_NET, B_IAC);
      queue_beat(REQ_NET, B_SE);
    end else if (pick < 79) begin
      queue_beat(REQ_NET, B_IAC);
      n = $urandom_range((hold_ticks < 8) ? hold_ticks + 1 : 3);
      for (int i = 0; i < n; i++) queue_beat(REQ_TICK, 8'($urandom));
    end else if (pick < 89) begin
      queue_beat(REQ_HOST, $urandom_range(2) == 0 ? B_IAC : 8'($urandom));
    end else if (pick < 94) begin
      queue_beat(REQ_TICK, 8'($urandom));
    end else if (pick < 97) begin
      queue_beat(req_t'($urandom_range(3)), 8'($urandom));
    end else begin
      queue_beat(REQ_LOST, 8'($urandom));
    end
  endtask

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drive_queue();
    foreach (stim_q[i]) send_item(stim_q[i]);
    in_if.valid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic wait_drained(input int unsigned settle);
    do @(negedge clk); while (queued_count != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned hold_table [PHASES];
    hold_table = '{3, 1, 5, 131071, 2, 7, 1, 4};
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_TELNET_EN;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    random_items = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: long hold, so a held IAC only leaves on connection loss.
    queue_beat(REQ_NET, 8'h00);
    queue_beat(REQ_HOST, B_IAC);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_TICK, 8'hff);
    queue_beat(REQ_LOST, 8'h00);
    drive_queue();
    wait_drained(8);
    write_reg(CFG_TIMEOUT, 17'd1);

    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, 8'h41);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_TICK, 8'h00);
    // Held IAC then a verb confirms Telnet.
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, B_WILL);
    queue_beat(REQ_NET, OPT_BINARY);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, B_DO);
    queue_beat(REQ_NET, 8'h18);
    queue_beat(REQ_HOST, B_IAC);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, B_SB);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, 8'h01);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, B_SE);
    queue_beat(REQ_NET, B_IAC);
    queue_beat(REQ_NET, 8'hf1);
    drive_queue();

    for (int p = 0; p < PHASES; p++) begin
      wait_drained(8);
      write_reg(CFG_TELNET_EN, (p % 4 == 2) ? '0 : CFG_DATA_W'(1));
      write_reg(CFG_TIMEOUT, CFG_DATA_W'(hold_table[p]));
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 83; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 83; end
        default: begin send_gap_pct = 32; stall_pct = 32; end
      endcase
      random_items = 0;
      while (random_items < PHASE_ITEMS) add_sequence(hold_table[p]);
      drive_queue();
    end

    wait_drained(20);
    $display("Run covered %0d input beats: negotiation, subnegotiation, held IAC and passthrough,",
             items_sent);
    $display("hold timeouts 1 to 131071 with idle and stall mixes; %0d output beats compared.",
             checked_count);
    if (error_count == 0) begin
      $display("tb_telnet_stream_filter_unit: clean");
    end else begin
      $display("tb_telnet_stream_filter_unit: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/tsf_pkg.sv
hdl/tsf_stream_if.sv
hdl/tsf_parser.sv
hdl/tsf_out_queue.sv
hdl/telnet_stream_filter_unit.sv
test/tsf_filter_checker.sv
test/tb_telnet_stream_filter_unit.sv
